/* hw/rtl/mvm_pkg.sv */
// Shared constants, payload types and controller/datapath interface types.
`default_nettype none

package mvm_pkg;

  localparam int MAX_DIM    = 16;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = 4;
  localparam int DIM_W      = 5;
  localparam int SUM_W      = 36;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [1:0] CMD_MAT_WR  = 2'd0;
  localparam logic [1:0] CMD_VEC_WR  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 2'd2;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic [IDX_W-1:0]             row;
    logic [IDX_W-1:0]             col;
    logic signed [DATA_WIDTH-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } out_rsp_t;

  typedef struct packed {
    logic              mat_we;
    logic              vec_we;
    logic              issue;
    logic              first;
    logic              elem_last;
    logic              out_last;
    logic [IDX_W-1:0]  out_idx;
    logic [ADDR_W-1:0] a_addr;
    logic [IDX_W-1:0]  x_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic adv;
    logic pipe_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/mvm_ctrl.sv */
// Controller: configuration registers, load decode and multiply-accumulate sequencer.
`default_nettype none

module mvm_ctrl
  import mvm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_req_t               in_req,
  input  wire dp_stat_t              stat,
  output dp_cmd_t                    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] row_count_r, col_count_r;
  logic             transpose_r;
  logic             tmode_r, tmode_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IDX_W-1:0] lim_out_r, lim_out_nxt, lim_in_r, lim_in_nxt;
  logic [IDX_W-1:0] lim_rows, lim_cols;
  logic             accept;

  function automatic logic [IDX_W-1:0] dim_limit(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] n;
    begin
      if (d == '0) begin
        n = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
        n = DIM_W'(MAX_DIM);
      end else begin
        n = d;
      end
      dim_limit = IDX_W'(n - DIM_W'(1));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(MAX_DIM);
      col_count_r <= DIM_W'(MAX_DIM);
      transpose_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_wdata;
        CFG_COL_COUNT: col_count_r <= cfg_wdata;
        CFG_TRANSPOSE: transpose_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign lim_rows = dim_limit(row_count_r);
  assign lim_cols = dim_limit(col_count_r);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    lim_out_nxt = lim_out_r;
    lim_in_nxt  = lim_in_r;
    tmode_nxt   = tmode_r;
    cmd         = '0;
    cmd.first     = (j_r == '0);
    cmd.elem_last = (j_r == lim_in_r);
    cmd.out_last  = (i_r == lim_out_r);
    cmd.out_idx   = i_r;
    cmd.x_addr    = j_r;
    cmd.a_addr    = tmode_r ? {j_r, i_r} : {i_r, j_r};
    unique case (state_r)
      S_IDLE: begin
        cmd.a_addr = {in_req.row, in_req.col};
        cmd.x_addr = in_req.col;
        if (accept) begin
          unique case (in_req.cmd)
            CMD_MAT_WR: cmd.mat_we = 1'b1;
            CMD_VEC_WR: cmd.vec_we = 1'b1;
            CMD_COMPUTE: begin
              tmode_nxt   = transpose_r;
              lim_out_nxt = transpose_r ? lim_cols : lim_rows;
              lim_in_nxt  = transpose_r ? lim_rows : lim_cols;
              i_nxt       = '0;
              j_nxt       = '0;
              state_nxt   = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (stat.adv) begin
          cmd.issue = 1'b1;
          if (j_r == lim_in_r) begin
            j_nxt = '0;
            if (i_r == lim_out_r) begin
              state_nxt = S_DRAIN;
            end else begin
              i_nxt = i_r + IDX_W'(1);
            end
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    lim_out_r <= lim_out_nxt;
    lim_in_r  <= lim_in_nxt;
    tmode_r   <= tmode_nxt;
  end

  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (j_r <= lim_in_r))
    else $error("inner index past limit");

  a_i_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (i_r <= lim_out_r))
    else $error("output index past limit");

  a_final_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && cmd.elem_last && cmd.out_last) |=> (state_r == S_DRAIN))
    else $error("sequencer missed end of run");

endmodule

`default_nettype wire

/* hw/rtl/mvm_datapath.sv */
// Datapath: matrix and vector stores, multiplier, accumulator and output register.
`default_nettype none

module mvm_datapath
  import mvm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  input  wire logic [DATA_WIDTH-1:0]  wr_value,
  output dp_stat_t                    stat,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_rsp_t                    out_rsp
);

  logic [DATA_WIDTH-1:0] mat_mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] vec_mem [MAX_DIM];

  logic                     adv;
  logic signed [DATA_WIDTH-1:0] a_rd_r, x_rd_r;
  logic                     s1_valid_r, s1_first_r, s1_elast_r, s1_olast_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s2_valid_r, s2_first_r, s2_elast_r, s2_olast_r;
  logic [IDX_W-1:0]         s2_idx_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt, prod_ext;
  logic                     out_valid_r;
  out_rsp_t                 out_rsp_r;

  assign adv            = !out_valid_r || out_ready;
  assign stat.adv       = adv;
  assign stat.pipe_busy = s1_valid_r || s2_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.mat_we) begin
      mat_mem[cmd.a_addr] <= wr_value;
    end
    if (adv && cmd.issue) begin
      a_rd_r <= mat_mem[cmd.a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vec_we) begin
      vec_mem[cmd.x_addr] <= wr_value;
    end
    if (adv && cmd.issue) begin
      x_rd_r <= vec_mem[cmd.x_addr];
    end
  end

  assign prod_ext = {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_nxt  = s2_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cmd.issue;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r && s2_elast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_first_r <= cmd.first;
      s1_elast_r <= cmd.elem_last;
      s1_olast_r <= cmd.out_last;
      s1_idx_r   <= cmd.out_idx;
      prod_r     <= a_rd_r * x_rd_r;
      s2_first_r <= s1_first_r;
      s2_elast_r <= s1_elast_r;
      s2_olast_r <= s1_olast_r;
      s2_idx_r   <= s1_idx_r;
      if (s2_valid_r) begin
        acc_r <= acc_nxt;
      end
      if (s2_valid_r && s2_elast_r) begin
        out_rsp_r.index <= s2_idx_r;
        out_rsp_r.sum   <= acc_nxt;
        out_rsp_r.last  <= s2_olast_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  a_write_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mat_we || cmd.vec_we) |-> (!s1_valid_r && !s2_valid_r))
    else $error("store write while products in flight");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> ($stable(s1_valid_r) && $stable(s2_valid_r)
                                     && $stable(acc_r)))
    else $error("pipeline moved during output stall");

  a_no_write_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !((cmd.mat_we || cmd.vec_we) && cmd.issue))
    else $error("store write and read issue together");

endmodule

`default_nettype wire

/* hw/rtl/matrix_vector_multiply.sv */
// Top level of the Q8.8 matrix-vector multiplier.
// Input channel (in_valid/in_ready/in_req) carries one request per item: a matrix
// entry write, a vector entry write or a compute command. Writes are taken one per
// cycle while idle and produce no result. A compute request walks the active matrix
// on one shared multiply-accumulate unit, one product per cycle while the output
// register is not stalled, and returns either A*x (row_count results) or
// A-transpose*x (col_count results), each count clamped to 1..16, on the output
// channel (out_valid/out_ready/out_rsp), each with its index and the final one marked
// last. Operands pass the store read registers, the product register and the
// accumulator; each finished sum is registered in the output register. in_ready
// returns once the pipeline has drained, while the last result may still wait in
// the output register. A stalled receiver holds the output register and freezes
// the whole pipeline. Reset (rst_n, synchronous) sets row_count and col_count to
// 16, transpose_mode to 0 and empties the pipeline; the matrix and vector stores
// hold no reset value. Configuration (cfg_we/cfg_index/cfg_wdata) must be written
// only while the block is idle; the user must ensure this, the block does not.
`default_nettype none

module matrix_vector_multiply
  import mvm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_req_t               in_req,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_rsp_t                   out_rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .stat      (stat),
    .cmd       (cmd)
  );

  mvm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_value  (in_req.value),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire
